// ----- rtl/core/irpd_pkg.sv -----
// package for the infrared pulse-distance decoder: result kinds, register map, match helper
package irpd_pkg;

    localparam int unsigned DUR_W   = 16;
    localparam int unsigned TOL_W   = 7;
    localparam int unsigned LIMIT_W = DUR_W + TOL_W;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned NUM_NOM = 6;

    // register indexes of the configuration port
    localparam logic [ADDR_W-1:0] REG_HDR_MARK  = 3'd0;
    localparam logic [ADDR_W-1:0] REG_HDR_SPACE = 3'd1;
    localparam logic [ADDR_W-1:0] REG_BIT_MARK  = 3'd2;
    localparam logic [ADDR_W-1:0] REG_ZERO_SP   = 3'd3;
    localparam logic [ADDR_W-1:0] REG_ONE_SP    = 3'd4;
    localparam logic [ADDR_W-1:0] REG_GAP_SP    = 3'd5;
    localparam logic [ADDR_W-1:0] REG_TOL       = 3'd6;

    typedef logic [DUR_W-1:0] nom_array_t [NUM_NOM];

    // reset values of the nominal durations, ordered by register index
    localparam nom_array_t NOM_RESET = '{16'd4380, 16'd4370, 16'd540,
                                         16'd540, 16'd1620, 16'd5480};
    localparam logic [TOL_W-1:0] TOL_RESET = 7'd25;

    typedef enum logic [1:0] {
        KIND_DATA      = 2'd0,
        KIND_GOOD_END  = 2'd1,
        KIND_ERROR_END = 2'd2
    } kind_t;

    // |measured - nominal| * 100 <= limit, limit being tolerance * nominal
    function automatic logic near_nominal(input logic [DUR_W-1:0] measured,
                                          input logic [DUR_W-1:0] nominal,
                                          input logic [LIMIT_W-1:0] limit);
        logic [DUR_W-1:0]   diff;
        logic [LIMIT_W-1:0] wide;
        logic [LIMIT_W-1:0] scaled;
        diff   = (measured >= nominal) ? (measured - nominal) : (nominal - measured);
        wide   = LIMIT_W'(diff);
        scaled = (wide << 6) + (wide << 5) + (wide << 2);
        return scaled <= limit;
    endfunction

endpackage

// ----- rtl/core/ir_pulse_distance_decoder_core.sv -----
// top level of the infrared pulse-distance decoder
//
// takes one measured mark/space pair (microseconds) per transaction and decodes
// header / bit / gap pairs into data bytes. each duration matches its nominal
// value when |measured - nominal| * 100 <= tolerance_percent * nominal. while
// idle a header pair opens a frame; inside a frame a one pair shifts in 1, a
// zero pair shifts in 0 (one is tested first), msb first, and every eighth bit
// emits a data byte (kind 0). any other pair closes the frame: a gap pair on a
// byte boundary gives a clean end (kind 1), anything else an error end (kind 2),
// and the block goes back to idle. frame_bytes counts bytes of the frame and
// saturates at 255. a pair is matched and decoded while it sits in the input
// register and its result lands in the output register when the decode pass
// moves; one pair can be taken every cycle while the output register is not
// stalled, and the rate is set by the single decode pass between
// the input register and the output register. the tolerance products are held
// in registers that are refreshed from the configuration port, so configuration
// writes must only happen while no pair is in flight. a pair that produces no
// result still waits for the output slot to be free or emptied, so a stalled
// output holds back the input.
module ir_pulse_distance_decoder_core
    import irpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration write port
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [DUR_W-1:0]  cfg_wdata,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // [15:0] mark_us, [31:16] space_us
    // output stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [7:0] out_byte, [15:8] frame_bytes
    output logic [1:0]        m_tuser    // [1:0] result_kind
);

    // configuration registers and precomputed tolerance limits
    logic [DUR_W-1:0]   nom_reg   [NUM_NOM];
    logic [DUR_W-1:0]   nom_next  [NUM_NOM];
    logic [LIMIT_W-1:0] limit_reg [NUM_NOM];
    logic [LIMIT_W-1:0] limit_next[NUM_NOM];
    logic [TOL_W-1:0]   tol_reg;
    logic [TOL_W-1:0]   tol_next;

    // input register
    logic               in_valid_reg;
    logic [DUR_W-1:0]   mark_reg;
    logic [DUR_W-1:0]   space_reg;

    // decoder state
    logic               in_frame_reg,  in_frame_next;
    logic [7:0]         shift_reg,     shift_next;
    logic [2:0]         bit_pos_reg,   bit_pos_next;
    logic [7:0]         byte_total_reg, byte_total_next;

    // output register
    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    logic [7:0]         frame_bytes_reg;
    kind_t              kind_reg;

    // decode results for the pair in the input register
    logic               emit;
    logic [7:0]         emit_byte;
    logic [7:0]         emit_count;
    kind_t              emit_kind;

    logic               advance;
    logic               hdr_match;
    logic               bit_mark_ok;
    logic               one_match;
    logic               zero_match;
    logic               gap_match;
    logic               new_bit;
    logic [7:0]         shifted;
    logic [2:0]         pos_inc;

    // config next values: nominals and tolerance, then the limits follow them
    always_comb
    begin
        tol_next = tol_reg;
        if (cfg_we && cfg_addr == REG_TOL)
        begin
            tol_next = cfg_wdata[TOL_W-1:0];
        end
        for (int i = 0; i < NUM_NOM; i++)
        begin
            nom_next[i] = nom_reg[i];
            if (cfg_we && cfg_addr == ADDR_W'(i))
            begin
                nom_next[i] = cfg_wdata;
            end
            limit_next[i] = LIMIT_W'(tol_next) * LIMIT_W'(nom_next[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
            for (int i = 0; i < NUM_NOM; i++)
            begin
                nom_reg[i]   <= NOM_RESET[i];
                limit_reg[i] <= LIMIT_W'(TOL_RESET) * LIMIT_W'(NOM_RESET[i]);
            end
        end
        else
        begin
            tol_reg <= tol_next;
            for (int i = 0; i < NUM_NOM; i++)
            begin
                nom_reg[i]   <= nom_next[i];
                limit_reg[i] <= limit_next[i];
            end
        end
    end

    // the decode pass moves when the output slot is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // duration matching
    always_comb
    begin
        hdr_match   = near_nominal(mark_reg,  nom_reg[REG_HDR_MARK],  limit_reg[REG_HDR_MARK])
                   && near_nominal(space_reg, nom_reg[REG_HDR_SPACE], limit_reg[REG_HDR_SPACE]);
        bit_mark_ok = near_nominal(mark_reg,  nom_reg[REG_BIT_MARK],  limit_reg[REG_BIT_MARK]);
        one_match   = bit_mark_ok
                   && near_nominal(space_reg, nom_reg[REG_ONE_SP],  limit_reg[REG_ONE_SP]);
        zero_match  = bit_mark_ok
                   && near_nominal(space_reg, nom_reg[REG_ZERO_SP], limit_reg[REG_ZERO_SP]);
        gap_match   = bit_mark_ok
                   && near_nominal(space_reg, nom_reg[REG_GAP_SP],  limit_reg[REG_GAP_SP]);
    end

    // frame decoding
    always_comb
    begin
        in_frame_next   = in_frame_reg;
        shift_next      = shift_reg;
        bit_pos_next    = bit_pos_reg;
        byte_total_next = byte_total_reg;
        emit            = 1'b0;
        emit_byte       = 8'd0;
        emit_count      = byte_total_reg;
        emit_kind       = KIND_DATA;
        new_bit         = one_match;
        shifted         = {shift_reg[6:0], new_bit};
        pos_inc         = bit_pos_reg + 3'd1;

        if (!in_frame_reg)
        begin
            // idle: only a header opens a frame, anything else is dropped
            if (hdr_match)
            begin
                in_frame_next   = 1'b1;
                shift_next      = 8'd0;
                bit_pos_next    = 3'd0;
                byte_total_next = 8'd0;
            end
        end
        else if (one_match || zero_match)
        begin
            shift_next   = shifted;
            bit_pos_next = pos_inc;
            if (pos_inc == 3'd0)
            begin
                // byte complete
                if (byte_total_reg != 8'hFF)
                begin
                    byte_total_next = byte_total_reg + 8'd1;
                end
                emit       = 1'b1;
                emit_byte  = shifted;
                emit_count = byte_total_next;
                emit_kind  = KIND_DATA;
                shift_next = 8'd0;
            end
        end
        else
        begin
            // frame closes; clean only for a gap on a byte boundary
            emit          = 1'b1;
            emit_kind     = (bit_pos_reg == 3'd0 && gap_match) ? KIND_GOOD_END
                                                               : KIND_ERROR_END;
            in_frame_next = 1'b0;
            shift_next    = 8'd0;
            bit_pos_next  = 3'd0;
        end
    end

    // input register, decoder state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            in_frame_reg   <= 1'b0;
            shift_reg      <= 8'd0;
            bit_pos_reg    <= 3'd0;
            byte_total_reg <= 8'd0;
            out_valid_reg  <= 1'b0;
            kind_reg       <= KIND_DATA;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end

            if (advance)
            begin
                in_frame_reg   <= in_frame_next;
                shift_reg      <= shift_next;
                bit_pos_reg    <= bit_pos_next;
                byte_total_reg <= byte_total_next;
            end

            if (advance)
            begin
                out_valid_reg <= emit;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance && emit)
            begin
                kind_reg <= emit_kind;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            mark_reg  <= s_tdata[15:0];
            space_reg <= s_tdata[31:16];
        end
        if (advance && emit)
        begin
            out_byte_reg    <= emit_byte;
            frame_bytes_reg <= emit_count;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {frame_bytes_reg, out_byte_reg};
    assign m_tuser  = kind_reg;

    // idle means no partial byte is held
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> (shift_reg == 8'd0 && bit_pos_reg == 3'd0))
        else $error("partial byte held while idle");

    // end results carry a zero byte
    a_end_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != KIND_DATA) |-> out_byte_reg == 8'd0)
        else $error("end result with non-zero byte");

    // an end result leaves the decoder idle
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit && emit_kind != KIND_DATA) |=> !in_frame_reg)
        else $error("frame still open after end result");

    // a result is only overwritten after it was taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !advance)
        else $error("pending result overwritten");

endmodule
